// ===== sv/aabb_pkg.sv =====
// Shared types and constants for the box table collision block.
`default_nettype none
package aabb_pkg;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_CLEAR   = 3'd1,
    OP_CHECK   = 3'd2,
    OP_RESOLVE = 3'd3,
    OP_GROUND  = 3'd4
  } op_t;

  // 0.05 in Q16.16, rounded to nearest
  localparam logic signed [32:0] GROUND_DROP = 33'sd3277;

  localparam int unsigned QW = 33;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        sx;
    logic [30:0]        sy;
    logic [30:0]        sz;
  } box_t;

  localparam int unsigned BOX_W = $bits(box_t);

  typedef struct packed {
    logic signed [QW-1:0] qx;
    logic signed [QW-1:0] qy;
    logic signed [QW-1:0] qz;
    logic [30:0]          sx;
    logic [30:0]          sy;
    logic [30:0]          sz;
  } query_t;

endpackage
`default_nettype wire

// ===== sv/aabb_in_if.sv =====
// Input channel: operation, positions and box size.
`default_nettype none
interface aabb_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;
  logic signed [31:0] new_z;
  logic [30:0]        size_x;
  logic [30:0]        size_y;
  logic [30:0]        size_z;

  modport source (
    output valid, operation, pos_x, pos_y, pos_z, new_x, new_y, new_z,
           size_x, size_y, size_z,
    input  ready
  );
  modport sink (
    input  valid, operation, pos_x, pos_y, pos_z, new_x, new_y, new_z,
           size_x, size_y, size_z,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/aabb_out_if.sv =====
// Output channel: hit and full flags and resolved position.
`default_nettype none
interface aabb_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic               table_full;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;

  modport source (
    output valid, hit, table_full, out_x, out_y, out_z,
    input  ready
  );
  modport sink (
    input  valid, hit, table_full, out_x, out_y, out_z,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/aabb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module aabb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/aabb_overlap.sv =====
// Three-axis overlap test of a query box against one stored box, on doubled centers.
`default_nettype none
module aabb_overlap (
  input  wire aabb_pkg::query_t query,
  input  wire aabb_pkg::box_t   box,
  output logic                  hit
);
  import aabb_pkg::*;

  function automatic logic axis_hit(logic signed [QW-1:0] q, logic [30:0] sq,
                                    logic signed [31:0] c, logic [30:0] sb);
    logic signed [QW:0] diff;
    logic [QW:0]        mag;
    logic [31:0]        sum;
    begin
      diff = {q[QW-1], q} - {{(QW-31){c[31]}}, c};
      mag  = diff[QW] ? (~diff + 1'b1) : diff;
      sum  = {1'b0, sq} + {1'b0, sb};
      axis_hit = ({mag, 1'b0} <= {{(QW-30){1'b0}}, sum});
    end
  endfunction

  always_comb begin
    hit = axis_hit(query.qx, query.sx, box.cx, box.sx) &&
          axis_hit(query.qy, query.sy, box.cy, box.sy) &&
          axis_hit(query.qz, query.sz, box.cz, box.sz);
  end

endmodule
`default_nettype wire

// ===== sv/aabb_box_table_collision.sv =====
// Top level: box table in RAM, scan sequencer and result register.
//
//   channel  | dir | payload
//   ---------+-----+--------------------------------------------------------
//   in_ch    | in  | operation, pos_x/y/z, new_x/y/z, size_x/y/z
//   out_ch   | out | hit, table_full, out_x/y/z
//
// Add, clear and unused codes go straight to S_EMIT, which loads the result register.
// Check and ground scan the table once; resolve scans it three times, one axis per pass,
// reading one box per cycle through the read port of the table RAM.
// Reset empties the table (count to zero); RAM contents are not cleared.
// One item at a time; a finished result waits in the output register while
// the next item is taken; a full output register stalls S_EMIT until it is read.
`default_nettype none
module aabb_box_table_collision #(
  parameter int unsigned MAX_BOXES = 64
) (
  input wire logic clk,
  input wire logic rst,
  aabb_in_if.sink    in_ch,
  aabb_out_if.source out_ch
);
  import aabb_pkg::*;

  localparam int unsigned AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BOXES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic          rd_pend;
  logic [1:0]    phase;
  logic [1:0]    last_phase;
  logic          phase_hit;
  logic          any_hit;
  logic          full_flag;

  logic signed [31:0] px, py, pz, ny, nz;
  logic signed [31:0] rx, ry, rz;
  query_t             query;

  logic  accept;
  op_t   op_in;
  logic  ram_we;
  box_t  wbox;
  box_t  rbox;
  logic  box_hit;
  logic  more;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state == S_IDLE);
  assign op_in        = op_t'(in_ch.operation);
  assign more         = (idx < count);

  assign ram_we   = accept && (op_in == OP_ADD) && (count < CNT_MAX);
  assign wbox.cx  = in_ch.pos_x;
  assign wbox.cy  = in_ch.pos_y;
  assign wbox.cz  = in_ch.pos_z;
  assign wbox.sx  = in_ch.size_x;
  assign wbox.sy  = in_ch.size_y;
  assign wbox.sz  = in_ch.size_z;

  aabb_ram #(
    .WIDTH (BOX_W),
    .DEPTH (MAX_BOXES),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (wbox),
    .raddr (idx[AW-1:0]),
    .rdata (rbox)
  );

  aabb_overlap u_overlap (
    .query (query),
    .box   (rbox),
    .hit   (box_hit)
  );

  logic out_valid;
  assign out_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            px          <= in_ch.pos_x;
            py          <= in_ch.pos_y;
            pz          <= in_ch.pos_z;
            ny          <= in_ch.new_y;
            nz          <= in_ch.new_z;
            query.sx    <= in_ch.size_x;
            query.sy    <= in_ch.size_y;
            query.sz    <= in_ch.size_z;
            query.qx    <= (op_in == OP_RESOLVE) ? {in_ch.new_x[31], in_ch.new_x}
                                                 : {in_ch.pos_x[31], in_ch.pos_x};
            query.qy    <= (op_in == OP_GROUND)
                           ? {in_ch.pos_y[31], in_ch.pos_y} - GROUND_DROP
                           : {in_ch.pos_y[31], in_ch.pos_y};
            query.qz    <= {in_ch.pos_z[31], in_ch.pos_z};
            idx         <= '0;
            rd_pend     <= 1'b0;
            phase       <= 2'd0;
            last_phase  <= (op_in == OP_RESOLVE) ? 2'd2 : 2'd0;
            phase_hit   <= 1'b0;
            any_hit     <= 1'b0;
            full_flag   <= (op_in == OP_ADD) && (count >= CNT_MAX);
            rx          <= (op_in == OP_RESOLVE) ? in_ch.new_x : '0;
            ry          <= (op_in == OP_RESOLVE) ? in_ch.new_y : '0;
            rz          <= (op_in == OP_RESOLVE) ? in_ch.new_z : '0;
            unique case (op_in)
              OP_ADD: begin
                if (count < CNT_MAX) begin
                  count <= count + 1'b1;
                end
                state <= S_EMIT;
              end
              OP_CLEAR: begin
                count <= '0;
                state <= S_EMIT;
              end
              OP_CHECK, OP_RESOLVE, OP_GROUND: begin
                state <= S_SCAN;
              end
              default: begin
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_SCAN: begin
          rd_pend <= more;
          if (more) begin
            idx <= idx + 1'b1;
          end
          if (rd_pend && box_hit) begin
            phase_hit <= 1'b1;
          end
          if (!more && !rd_pend) begin
            any_hit   <= any_hit | phase_hit;
            idx       <= '0;
            phase_hit <= 1'b0;
            if (last_phase != 2'd0) begin
              unique case (phase)
                2'd0: begin
                  if (phase_hit) begin
                    rx       <= px;
                    query.qx <= {px[31], px};
                  end
                  query.qy <= {ny[31], ny};
                end
                2'd1: begin
                  if (phase_hit) begin
                    ry       <= py;
                    query.qy <= {py[31], py};
                  end
                  query.qz <= {nz[31], nz};
                end
                default: begin
                  if (phase_hit) begin
                    rz <= pz;
                  end
                end
              endcase
            end
            if (phase == last_phase) begin
              state <= S_EMIT;
            end else begin
              phase <= phase + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid         <= 1'b1;
            out_ch.hit        <= any_hit;
            out_ch.table_full <= full_flag;
            out_ch.out_x      <= rx;
            out_ch.out_y      <= ry;
            out_ch.out_z      <= rz;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
